### hdl/blmm_pkg.sv
// Shared types, constants and helpers for the blocked-layout matrix multiplier.
package blmm_pkg;

	localparam int ACC_BITS     = 40;
	localparam int POS_BITS     = 6;
	localparam int CFG_BITS     = 4;
	localparam int CFG_IDX_BITS = 1;
	localparam int COUNT_BITS   = 8;

	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE_IN_USE = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_TILE_SIZE   = 1'd1;

	localparam logic [CFG_BITS-1:0] SIZE_RESET = 4'd8;
	localparam logic [CFG_BITS-1:0] TILE_RESET = 4'd2;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_CALC,
		ST_WAIT,
		ST_BAD
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;     // pair transaction taken
		logic start;    // final pair taken, load count returns to zero
		logic rd_en;    // one product term issued this cycle
		logic first_k;
		logic last_k;
		logic push;     // move a result into the output register
		logic bad_run;  // result carries zero and the error flag
		logic run_end;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic acc_ready;
		logic out_free;
	} ctl_sts_t;

	// true when some m in 1..15 gives t*m == n
	function automatic logic tile_divides(logic [CFG_BITS-1:0] n, logic [CFG_BITS-1:0] t);
		logic hit;
		hit = 1'b0;
		for (int m = 1; m < 16; m++) begin
			if (8'(t) * 8'(m) == 8'(n)) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

### hdl/blmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### hdl/blmm_ctrl.sv
// Controller: configuration registers, run state machine and tile/element counters.
module blmm_ctrl import blmm_pkg::*; #(
	parameter int MAX_DIM = 8
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
	input  logic [CFG_BITS-1:0]                      cfg_data,
	input  logic                                     pair_valid,
	input  logic                                     final_pair,
	output logic                                     pair_stall,
	input  ctl_sts_t                                 sts,
	output ctl_cmd_t                                 cmd,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_addr,
	output logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_addr,
	output logic [POS_BITS-1:0]                      position
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW    = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [CFG_BITS-1:0] size_q, tile_q;

	// k walk inside one element: kk within the tile, kg over the whole row
	logic [IW-1:0] kk_q, kg_q, bka_q, bkb_q;
	// element walk in blocked row order
	logic [IW-1:0] j_q, jt_q, i_q, it_q, bj_q, bjt_q, bi_q, bin_q;
	logic [IW-1:0] idx_q;

	logic [IW-1:0] n_i, t_i, tt_i, tn_i;
	logic [COUNT_BITS-1:0] run_count;
	logic layout_bad, last_idx, last_k;
	logic j_last, i_last, bj_last, bi_last, elem_done;
	logic pair_acc;

	assign n_i  = IW'(size_q);
	assign t_i  = IW'(tile_q);
	assign tt_i = IW'(8'(tile_q) * 8'(tile_q));
	assign tn_i = IW'(8'(tile_q) * 8'(size_q));

	assign layout_bad = (size_q == '0) || (int'(size_q) > MAX_DIM) || (tile_q == '0) ||
		!tile_divides(size_q, tile_q);
	assign run_count = (size_q != '0 && int'(size_q) <= MAX_DIM) ?
		8'(size_q) * 8'(size_q) : COUNT_BITS'(1);
	assign last_idx = (COUNT_BITS'(idx_q) == run_count - COUNT_BITS'(1));

	assign last_k    = (kg_q == n_i - IW'(1));
	assign j_last    = (j_q == t_i - IW'(1));
	assign i_last    = (i_q == t_i - IW'(1));
	assign bj_last   = (bj_q + t_i == n_i);
	assign bi_last   = (bi_q + t_i == n_i);
	assign elem_done = j_last && i_last && bj_last && bi_last;

	assign a_addr   = AW'(bin_q + it_q + bka_q + kk_q);
	assign b_addr   = AW'(bjt_q + jt_q + bkb_q + kk_q);
	assign position = POS_BITS'(idx_q);

	assign pair_stall = (state_q != ST_LOAD);
	assign pair_acc   = pair_valid && !pair_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.run_end = last_idx;
		unique case (state_q)
			ST_LOAD: begin
				cmd.load  = pair_acc;
				cmd.start = pair_acc && final_pair;
				if (pair_acc && final_pair) begin
					state_d = layout_bad ? ST_BAD : ST_CALC;
				end
			end
			ST_CALC: begin
				cmd.rd_en   = 1'b1;
				cmd.first_k = (kg_q == '0);
				cmd.last_k  = last_k;
				if (last_k) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				cmd.push = sts.acc_ready && sts.out_free;
				if (cmd.push) begin
					state_d = elem_done ? ST_LOAD : ST_CALC;
				end
			end
			ST_BAD: begin
				cmd.bad_run = 1'b1;
				cmd.push    = sts.out_free;
				if (sts.out_free && last_idx) begin
					state_d = ST_LOAD;
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
			tile_q <= TILE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SIZE_IN_USE: size_q <= cfg_data;
				REG_TILE_SIZE:   tile_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kk_q  <= '0;
			kg_q  <= '0;
			bka_q <= '0;
			bkb_q <= '0;
			j_q   <= '0;
			jt_q  <= '0;
			i_q   <= '0;
			it_q  <= '0;
			bj_q  <= '0;
			bjt_q <= '0;
			bi_q  <= '0;
			bin_q <= '0;
			idx_q <= '0;
		end else if (cmd.start) begin
			kk_q  <= '0;
			kg_q  <= '0;
			bka_q <= '0;
			bkb_q <= '0;
			j_q   <= '0;
			jt_q  <= '0;
			i_q   <= '0;
			it_q  <= '0;
			bj_q  <= '0;
			bjt_q <= '0;
			bi_q  <= '0;
			bin_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				ST_CALC: begin
					if (last_k) begin
						kk_q  <= '0;
						kg_q  <= '0;
						bka_q <= '0;
						bkb_q <= '0;
					end else begin
						kg_q <= kg_q + IW'(1);
						// crossing into the next k tile jumps a whole tile in A and a tile row in B
						if (kk_q == t_i - IW'(1)) begin
							kk_q  <= '0;
							bka_q <= bka_q + tt_i;
							bkb_q <= bkb_q + tn_i;
						end else begin
							kk_q <= kk_q + IW'(1);
						end
					end
				end
				ST_WAIT: begin
					if (cmd.push) begin
						idx_q <= idx_q + IW'(1);
						if (!j_last) begin
							j_q  <= j_q + IW'(1);
							jt_q <= jt_q + t_i;
						end else begin
							j_q  <= '0;
							jt_q <= '0;
							if (!i_last) begin
								i_q  <= i_q + IW'(1);
								it_q <= it_q + t_i;
							end else begin
								i_q  <= '0;
								it_q <= '0;
								if (!bj_last) begin
									bj_q  <= bj_q + t_i;
									bjt_q <= bjt_q + tt_i;
								end else begin
									bj_q  <= '0;
									bjt_q <= '0;
									bi_q  <= bi_q + t_i;
									bin_q <= bin_q + tn_i;
								end
							end
						end
					end
				end
				ST_BAD: begin
					if (cmd.push) begin
						idx_q <= idx_q + IW'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

### hdl/blmm_dp.sv
// Datapath: element stores, multiply-accumulate pipeline and output register.
module blmm_dp import blmm_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  ctl_cmd_t                                 cmd,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] a_addr,
	input  logic [((MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1)-1:0] b_addr,
	input  logic [POS_BITS-1:0]                      position,
	input  logic signed [ELEM_BITS-1:0]              a_element,
	input  logic signed [ELEM_BITS-1:0]              b_element,
	output ctl_sts_t                                 sts,
	input  logic                                     result_stall,
	output logic                                     result_valid,
	output logic signed [ACC_BITS-1:0]               c_element,
	output logic [POS_BITS-1:0]                      c_position,
	output logic                                     run_end,
	output logic                                     layout_error
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LW    = $clog2(DEPTH + 1);
	localparam int PW    = 2 * ELEM_BITS;
	localparam int SW    = (PW + 1 > ACC_BITS + 1) ? PW + 1 : ACC_BITS + 1;
	localparam logic signed [SW-1:0] SAT_HI = {{(SW - ACC_BITS + 1){1'b0}}, {(ACC_BITS - 1){1'b1}}};
	localparam logic signed [SW-1:0] SAT_LO = {{(SW - ACC_BITS + 1){1'b1}}, {(ACC_BITS - 1){1'b0}}};

	logic [LW-1:0] load_cnt_q;
	logic [DEPTH-1:0] written_q;
	logic store_we;

	logic [ELEM_BITS-1:0] a_rd, b_rd;
	logic a_ok_s1, b_ok_s1;
	logic rd_s1, first_s1, last_s1;
	logic rd_s2, first_s2, last_s2;
	logic signed [ELEM_BITS-1:0] a_s1, b_s1;
	logic signed [PW-1:0] prod_s2;

	logic signed [ACC_BITS-1:0] acc_q;
	logic acc_ready_q;
	logic signed [SW-1:0] sum;
	logic signed [ACC_BITS-1:0] sum_sat;

	assign store_we = cmd.load && (load_cnt_q < LW'(DEPTH));

	blmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_a_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (load_cnt_q[AW-1:0]),
		.wdata (a_element),
		.raddr (a_addr),
		.rdata (a_rd)
	);

	blmm_ram #(.WIDTH(ELEM_BITS), .DEPTH(DEPTH)) u_b_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (load_cnt_q[AW-1:0]),
		.wdata (b_element),
		.raddr (b_addr),
		.rdata (b_rd)
	);

	// entries never loaded since reset read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			written_q  <= '0;
		end else begin
			if (store_we) begin
				written_q[load_cnt_q[AW-1:0]] <= 1'b1;
			end
			if (cmd.start) begin
				load_cnt_q <= '0;
			end else if (store_we) begin
				load_cnt_q <= load_cnt_q + LW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1 <= 1'b0;
			rd_s2 <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd_en;
			rd_s2 <= rd_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_ok_s1  <= written_q[a_addr];
		b_ok_s1  <= written_q[b_addr];
		first_s1 <= cmd.first_k;
		last_s1  <= cmd.last_k;
		first_s2 <= first_s1;
		last_s2  <= last_s1;
		prod_s2  <= a_s1 * b_s1;
	end

	assign a_s1 = a_ok_s1 ? signed'(a_rd) : '0;
	assign b_s1 = b_ok_s1 ? signed'(b_rd) : '0;

	// saturating add, first term starts from zero
	always_comb begin
		sum = (first_s2 ? '0 : SW'(acc_q)) + SW'(prod_s2);
		if (sum > SAT_HI) begin
			sum_sat = SAT_HI[ACC_BITS-1:0];
		end else if (sum < SAT_LO) begin
			sum_sat = SAT_LO[ACC_BITS-1:0];
		end else begin
			sum_sat = sum[ACC_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rd_s2) begin
			acc_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_ready_q <= 1'b0;
		end else if (rd_s2 && last_s2) begin
			acc_ready_q <= 1'b1;
		end else if (cmd.push) begin
			acc_ready_q <= 1'b0;
		end
	end

	assign sts.acc_ready = acc_ready_q;
	assign sts.out_free  = !result_valid || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.push) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			c_element    <= cmd.bad_run ? '0 : acc_q;
			c_position   <= position;
			run_end      <= cmd.run_end;
			layout_error <= cmd.bad_run;
		end
	end

endmodule

### hdl/blocked_layout_matrix_multiply.sv
// Blocked-layout matrix multiplier, top level. Element pairs of A (tiled row-major,
// tiles row-major) and B (tiled column-major, tiles row-major) load one pair per cycle
// while pair_stall is low. The pair marked final_pair starts the product: each C element
// is formed as a dot product over k, one term per cycle through a shared multiplier and
// saturating accumulator, and the results leave in blocked row-major order with their
// index. Elements are computed one at a time through the single multiply-accumulate unit
// and the registered store reads; pair_stall is high for the whole run. If tile_size does
// not divide size_in_use the block emits n*n zero results (one if n is out of range) with
// layout_error set, at one per cycle while result_stall is low. Inputs are Q5.11,
// results Q18.22 in 40 bits. Write configuration only while the block is idle.
module blocked_layout_matrix_multiply import blmm_pkg::*; #(
	parameter int MAX_DIM   = 8,
	parameter int ELEM_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [CFG_BITS-1:0]         cfg_data,
	input  logic                        pair_valid,
	output logic                        pair_stall,
	input  logic signed [ELEM_BITS-1:0] a_element,
	input  logic signed [ELEM_BITS-1:0] b_element,
	input  logic                        final_pair,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [ACC_BITS-1:0]  c_element,
	output logic [POS_BITS-1:0]         c_position,
	output logic                        run_end,
	output logic                        layout_error
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	ctl_cmd_t cmd;
	ctl_sts_t sts;
	logic [AW-1:0] a_addr, b_addr;
	logic [POS_BITS-1:0] position;

	blmm_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.pair_valid (pair_valid),
		.final_pair (final_pair),
		.pair_stall (pair_stall),
		.sts        (sts),
		.cmd        (cmd),
		.a_addr     (a_addr),
		.b_addr     (b_addr),
		.position   (position)
	);

	blmm_dp #(.MAX_DIM(MAX_DIM), .ELEM_BITS(ELEM_BITS)) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.a_addr       (a_addr),
		.b_addr       (b_addr),
		.position     (position),
		.a_element    (a_element),
		.b_element    (b_element),
		.sts          (sts),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.c_element    (c_element),
		.c_position   (c_position),
		.run_end      (run_end),
		.layout_error (layout_error)
	);

endmodule
